// ----- hw/rtl/cscc_pkg.sv -----
package cscc_pkg;

  localparam int NumSlotsDef = 16;

  localparam int OpW      = 2;
  localparam int SlotW    = 8;
  localparam int SampleW  = 13;
  localparam int ChanW    = 5;
  localparam int CtlW     = 7;
  localparam int ShiftW   = 3;
  localparam int LevelW   = 17;
  localparam int ProdW    = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;
  localparam int InDataW  = 24;
  localparam int InUserW  = 3;
  localparam int OutDataW = 24;

  localparam logic [OpW-1:0] OP_READING = 2'd0;
  localparam logic [OpW-1:0] OP_TICK    = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR   = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_CHANNEL   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_CTL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT     = 2'd2;

  localparam logic [ChanW-1:0]   CHANNEL_RST   = 5'd1;
  localparam logic [CtlW-1:0]    FIRST_CTL_RST = 7'd0;
  localparam logic [ShiftW-1:0]  SHIFT_RST     = 3'd2;

  localparam logic [SampleW-1:0] FULL_Q12 = 13'd4096;
  localparam logic [LevelW-1:0]  HALF_Q16 = 17'd32768;
  localparam logic [CtlW-1:0]    CC_MAX   = 7'd127;

  typedef struct packed {
    logic load;
    logic apply_read;
    logic clear;
    logic scan_start;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           hit;
    logic           scan_last;
    logic           pend_valid;
    logic           out_free;
  } sts_t;

endpackage

// ----- hw/rtl/cscc_ctrl.sv -----
module cscc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  cscc_pkg::sts_t sts,
  output cscc_pkg::cmd_t cmd
);
  import cscc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.load   = s_tvalid && s_tready;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (sts.op)
          OP_READING: cmd.apply_read = 1'b1;
          OP_CLEAR:   cmd.clear = 1'b1;
          OP_TICK: begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        // hold the slot while a pending message cannot move to the output
        cmd.step = !(sts.hit && sts.pend_valid && !sts.out_free);
        if (cmd.step && sts.scan_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush = !sts.pend_valid || sts.out_free;
        if (cmd.flush) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/cscc_dp.sv -----
module cscc_dp #(
  parameter int NUM_SLOTS = cscc_pkg::NumSlotsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cscc_pkg::cmd_t                 cmd,
  output cscc_pkg::sts_t                 sts,
  input  logic [cscc_pkg::InDataW-1:0]   s_tdata,
  input  logic [cscc_pkg::InUserW-1:0]   s_tuser,
  input  logic                           cfg_valid,
  input  logic [cscc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cscc_pkg::CfgDataW-1:0]  cfg_data,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cscc_pkg::OutDataW-1:0]  m_tdata,
  output logic                           m_tlast
);
  import cscc_pkg::*;

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  logic [ChanW-1:0]   channel;
  logic [CtlW-1:0]    first_ctl;
  logic [ShiftW-1:0]  shift;

  logic [OpW-1:0]     item_op;
  logic [SlotW-1:0]   item_slot;
  logic               item_kind;
  logic [SampleW-1:0] item_sample;

  logic [LevelW-1:0]  level [NUM_SLOTS];
  logic               is_btn [NUM_SLOTS];
  logic [CtlW-1:0]    sent_value [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [NUM_SLOTS-1:0] sent_valid;

  logic               scanning;
  logic [IdxW-1:0]    idx;
  logic               pend_valid;
  logic [CtlW-1:0]    pend_number;
  logic [CtlW-1:0]    pend_value;
  logic [ChanW-1:0]   out_chan;
  logic [CtlW-1:0]    out_num;
  logic [CtlW-1:0]    out_val;

  logic               slot_ok;
  logic [IdxW-1:0]    slot_idx;
  logic [IdxW-1:0]    rd_idx;
  logic [LevelW-1:0]  cur_level;
  logic               cur_valid;
  logic [SampleW-1:0] sample_sat;
  logic [LevelW-1:0]  v;
  logic [LevelW-1:0]  s_old;
  logic signed [LevelW:0] diff;
  logic signed [LevelW:0] delta;
  logic signed [LevelW:0] sum;
  logic [LevelW-1:0]  new_level;
  logic [ProdW-1:0]   prod;
  logic [ProdW-1:0]   rounded;
  logic [CtlW-1:0]    pot_val;
  logic [CtlW-1:0]    cc_val;
  logic               hit;
  logic [CtlW-1:0]    cur_number;
  logic               out_free;
  logic               push_mid;
  logic               push_end;

  assign slot_ok   = item_slot < SlotW'(NUM_SLOTS);
  assign slot_idx  = item_slot[IdxW-1:0];
  assign rd_idx    = scanning ? idx : slot_idx;
  assign cur_level = level[rd_idx];
  assign cur_valid = slot_valid[rd_idx];

  // reading update: arithmetic shift of the signed difference; a button takes the sample as is
  assign sample_sat = (item_sample > FULL_Q12) ? FULL_Q12 : item_sample;
  assign v          = {sample_sat, 4'b0000};
  assign s_old      = cur_valid ? cur_level : '0;
  assign diff       = $signed({1'b0, v}) - $signed({1'b0, s_old});
  assign delta      = diff >>> shift;
  assign sum        = $signed({1'b0, s_old}) + delta;
  assign new_level  = item_kind ? v : sum[LevelW-1:0];

  // controller value, round half up; a button gives CC_MAX from half level up, else zero
  assign prod    = ProdW'(cur_level) * ProdW'(CC_MAX);
  assign rounded = prod + ProdW'(HALF_Q16);
  assign pot_val = (rounded[ProdW-1:16] > 8'(CC_MAX)) ? CC_MAX : rounded[22:16];
  assign cc_val  = is_btn[rd_idx] ? ((cur_level >= HALF_Q16) ? CC_MAX : '0) : pot_val;

  assign hit = cur_valid && !(sent_valid[rd_idx] && (sent_value[rd_idx] == cc_val));
  assign cur_number = first_ctl + CtlW'(idx);

  assign out_free = !m_tvalid || m_tready;
  assign push_mid = cmd.step && hit && pend_valid;
  assign push_end = cmd.flush && pend_valid;

  assign sts.op         = item_op;
  assign sts.hit        = hit;
  assign sts.scan_last  = (idx == LastIdx);
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

  assign m_tdata = {5'b00000, out_val, out_num, out_chan};

  always_ff @(posedge clk) begin
    if (rst) begin
      channel   <= CHANNEL_RST;
      first_ctl <= FIRST_CTL_RST;
      shift     <= SHIFT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHANNEL:   channel <= cfg_data[ChanW-1:0];
        CFG_FIRST_CTL: first_ctl <= cfg_data[CtlW-1:0];
        CFG_SHIFT:     shift <= cfg_data[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_slot   <= s_tdata[SlotW-1:0];
      item_sample <= s_tdata[SlotW+SampleW-1:SlotW];
      item_op     <= s_tuser[OpW-1:0];
      item_kind   <= s_tuser[OpW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      sent_valid <= '0;
    end else if (cmd.clear) begin
      slot_valid <= '0;
      sent_valid <= '0;
    end else begin
      if (cmd.apply_read && slot_ok) slot_valid[slot_idx] <= 1'b1;
      if (cmd.step && hit) sent_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_read && slot_ok) begin
      level[slot_idx]  <= new_level;
      is_btn[slot_idx] <= item_kind;
    end
    if (cmd.step && hit) sent_value[idx] <= cc_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      scanning   <= 1'b1;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.step) begin
      if (!sts.scan_last) idx <= idx + 1'b1;
      if (hit) pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      scanning   <= 1'b0;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && hit) begin
      pend_number <= cur_number;
      pend_value  <= cc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push_mid || push_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_end) begin
      out_chan <= channel;
      out_num  <= pend_number;
      out_val  <= pend_value;
      m_tlast  <= push_end;
    end
  end

endmodule

// ----- hw/rtl/control_slot_to_midi_cc_core.sv -----
// Reading or clear: slot state written in the cycle after the transfer; no new item until then.
// Tick: the scan counter steps one slot per cycle, holding while a found message waits for
// the output register; a message moves to the output when the next one is found, the final
// one at the end of the scan.
// A finished message waits in the output register while the next item is taken.
// Reset (rst, synchronous, active high) empties all slots and loads the register defaults;
// no clearing pass, ready in the first cycle after reset.
module control_slot_to_midi_cc_core #(
  parameter int NUM_SLOTS = cscc_pkg::NumSlotsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cscc_pkg::InDataW-1:0]   s_tdata,  // slot, sample_value, zero pad
  input  logic [cscc_pkg::InUserW-1:0]   s_tuser,  // operation, kind
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cscc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cscc_pkg::CfgDataW-1:0]  cfg_data,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cscc_pkg::OutDataW-1:0]  m_tdata,  // cc_channel, cc_number, cc_value, zero pad
  output logic                           m_tlast
);
  import cscc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cscc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cscc_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTHESIS
  a_step_flush_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && cmd.flush))
    else $error("scan step and flush together");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !sts.pend_valid)
    else $error("pending message left at idle");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.hit && sts.pend_valid) |-> sts.out_free)
    else $error("message pushed into a full output register");

  a_flush_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> s_tready)
    else $error("flush did not return to idle");
`endif

endmodule
